// ===== hw/rtl/psrle_pkg.sv =====
package psrle_pkg;

   localparam int DEF_SCREEN_WIDTH  = 320;
   localparam int DEF_SCREEN_HEIGHT = 200;
   localparam int DEF_PLANE_COUNT   = 4;

   localparam int ADDR_W   = 17;
   localparam int COUNT_W  = 14;
   localparam int BYTE_W   = 8;
   localparam int OP_W     = 2;
   localparam int ORGX_W   = 9;
   localparam int ORGY_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int RSP_DATA_W = 40;

   localparam logic [1:0] PH_LOW     = 2'd0;
   localparam logic [1:0] PH_HIGH    = 2'd1;
   localparam logic [1:0] PH_DATA    = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   localparam logic [1:0] CMD_END    = 2'd0;
   localparam logic [1:0] CMD_SKIP   = 2'd1;
   localparam logic [1:0] CMD_REPEAT = 2'd2;
   localparam logic [1:0] CMD_COPY   = 2'd3;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_TINT  = 2'd1;
   localparam logic [OP_W-1:0] OP_END   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT_MODE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    run_op;
      logic               out_of_screen;
      logic [BYTE_W-1:0]  pixel_value;
      logic [COUNT_W-1:0] run_length;
      logic [ADDR_W-1:0]  run_address;
   } run_type;

endpackage

// ===== hw/rtl/planar_sprite_rle_decoder.sv =====
// Planar sprite run-length decoder.
// req channel: one compressed stream byte per transfer (req_tdata[7:0]).
// csr channel: register writes (0 origin_x, 1 origin_y, 2 tint_mode); always
// ready; the user must write it only while the decoder is idle (not enforced).
// A new origin reloads the destination at image start and at each plane end.
// rsp channel: pixel-write runs and the image-end marker; run_op on rsp_tuser,
// address, length, value and out-of-screen flag packed in rsp_tdata.
// Throughput: one byte per cycle unless the skid entry is full. All decode state
// updates at the byte's transfer; its run, if any, goes to the result register or,
// on a stall, the skid entry. The origin multiply and address add set the path.
// Stall: a result register plus one skid entry hold runs while rsp_tready is
// low; req_tready drops only once the skid entry is occupied.
// Reset: parse state returns to awaiting a control low byte, plane 0, origin
// and tint mode 0, both output entries empty.
module planar_sprite_rle_decoder #(
   parameter int SCREEN_WIDTH  = psrle_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = psrle_pkg::DEF_SCREEN_HEIGHT,
   parameter int PLANE_COUNT   = psrle_pkg::DEF_PLANE_COUNT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [psrle_pkg::BYTE_W-1:0]         req_tdata,   // [7:0] stream_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [16:0] run_address, [30:17] run_length, [38:31] pixel_value, [39] out_of_screen
   output logic [psrle_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [psrle_pkg::OP_W-1:0]           rsp_tuser,   // [1:0] run_op
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [psrle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psrle_pkg::CSR_DATA_W-1:0]     csr_data
);
   import psrle_pkg::*;

   localparam int PLANE_W    = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int SCREEN_END = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int END_W      = $clog2(SCREEN_END + 1);
   localparam int CMP_W      = ((END_W > ADDR_W) ? END_W : ADDR_W) + 1;

   logic [ORGX_W-1:0]  origin_x_ff;
   logic [ORGY_W-1:0]  origin_y_ff;
   logic               tint_mode_ff;

   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [1:0]         phase_ff, phase_in;
   logic [BYTE_W-1:0]  ctl_low_ff, ctl_low_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [ADDR_W-1:0]  dest_ff, dest_in;
   logic               image_start_ff, image_start_in;

   logic               out_valid_ff, skid_valid_ff;
   run_type            out_ff, skid_ff;

   logic               accept, csr_fire, rsp_fire;
   logic               emit;
   run_type            run_new;
   logic [ADDR_W-1:0]  origin_base, dest_cur, run_addr;
   logic [1:0]         hi_cmd;
   logic [COUNT_W-1:0] hi_count, remain_dec;
   logic [ADDR_W-1:0]  advance_count;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_fire   = out_valid_ff && rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.run_op;
   assign rsp_tdata  = {out_ff.out_of_screen, out_ff.pixel_value,
                        out_ff.run_length, out_ff.run_address};

   assign origin_base = ADDR_W'(ADDR_W'(origin_y_ff) * ADDR_W'(SCREEN_WIDTH))
                        + ADDR_W'(origin_x_ff);
   assign dest_cur    = image_start_ff ? origin_base : dest_ff;
   assign hi_cmd      = req_tdata[7:6];
   assign hi_count    = {req_tdata[5:0], ctl_low_ff};
   assign remain_dec  = remain_ff - COUNT_W'(1);
   assign advance_count = {1'b0, hi_count, 2'b00};

   always_comb begin
      plane_in       = plane_ff;
      phase_in       = phase_ff;
      ctl_low_in     = ctl_low_ff;
      cmd_in         = cmd_ff;
      remain_in      = remain_ff;
      dest_in        = dest_cur;
      image_start_in = 1'b0;
      emit           = 1'b0;
      run_addr       = dest_cur;
      run_new.run_op        = OP_WRITE;
      run_new.run_length    = '0;
      run_new.pixel_value   = '0;
      run_new.run_address   = '0;
      run_new.out_of_screen = 1'b0;
      case (phase_ff)
         PH_LOW: begin
            ctl_low_in = req_tdata;
            phase_in   = PH_HIGH;
         end
         PH_HIGH: begin
            cmd_in    = hi_cmd;
            remain_in = hi_count;
            phase_in  = PH_LOW;
            case (hi_cmd)
               CMD_END: begin
                  if (plane_ff == PLANE_W'(PLANE_COUNT - 1)) begin
                     plane_in       = '0;
                     image_start_in = 1'b1;
                     emit           = 1'b1;
                     run_new.run_op = OP_END;
                  end else begin
                     plane_in = plane_ff + PLANE_W'(1);
                     dest_in  = origin_base + ADDR_W'(plane_ff) + ADDR_W'(1);
                  end
               end
               CMD_SKIP: begin
                  dest_in = dest_cur + advance_count;
               end
               default: begin
                  if (tint_mode_ff) begin
                     dest_in   = dest_cur + advance_count;
                     remain_in = (hi_cmd == CMD_REPEAT) ? COUNT_W'(1) : hi_count;
                     if (remain_in != '0) begin
                        phase_in = PH_DISCARD;
                     end
                     emit                = (hi_count != '0);
                     run_new.run_op      = OP_TINT;
                     run_new.run_address = dest_cur;
                     run_new.run_length  = hi_count;
                  end else if (hi_cmd == CMD_REPEAT || hi_count != '0) begin
                     phase_in = PH_DATA;
                  end
               end
            endcase
         end
         PH_DISCARD: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_LOW;
            end
         end
         default: begin
            run_new.run_address = dest_cur;
            run_new.pixel_value = req_tdata;
            if (cmd_ff == CMD_REPEAT) begin
               phase_in           = PH_LOW;
               remain_in          = '0;
               dest_in            = dest_cur + {1'b0, remain_ff, 2'b00};
               emit               = (remain_ff != '0);
               run_new.run_length = remain_ff;
            end else begin
               dest_in            = dest_cur + ADDR_W'(4);
               remain_in          = remain_dec;
               if (remain_dec == '0) begin
                  phase_in = PH_LOW;
               end
               emit               = 1'b1;
               run_new.run_length = COUNT_W'(1);
            end
         end
      endcase
      run_addr = run_new.run_address;
      run_new.out_of_screen = (run_new.run_op != OP_END) &&
                              (CMP_W'(run_addr) >= CMP_W'(SCREEN_END));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         tint_mode_ff   <= 1'b0;
         plane_ff       <= '0;
         phase_ff       <= PH_LOW;
         ctl_low_ff     <= '0;
         cmd_ff         <= CMD_END;
         remain_ff      <= '0;
         dest_ff        <= '0;
         image_start_ff <= 1'b1;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_ORIGIN_X:  origin_x_ff  <= csr_data[ORGX_W-1:0];
               CSR_ORIGIN_Y:  origin_y_ff  <= csr_data[ORGY_W-1:0];
               CSR_TINT_MODE: tint_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            plane_ff       <= plane_in;
            phase_ff       <= phase_in;
            ctl_low_ff     <= ctl_low_in;
            cmd_ff         <= cmd_in;
            remain_ff      <= remain_in;
            dest_ff        <= dest_in;
            image_start_ff <= image_start_in;
         end
         if (!out_valid_ff || rsp_fire) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept && emit;
            end
         end else if (accept && emit) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept && emit) begin
            out_ff <= run_new;
         end
      end else if (accept && emit) begin
         skid_ff <= run_new;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry occupied while result register empty");

   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.run_op == OP_END) |->
      (out_ff.run_address == '0 && out_ff.run_length == '0 &&
       out_ff.pixel_value == '0 && !out_ff.out_of_screen))
      else $error("image end marker carries a nonzero field");

   a_op_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.run_op == OP_WRITE || out_ff.run_op == OP_TINT ||
                        out_ff.run_op == OP_END))
      else $error("undefined run op on result");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && run_new.run_op == OP_END) |=>
      (image_start_ff && plane_ff == '0 && phase_ff == PH_LOW))
      else $error("image end did not return to image start");

   a_data_not_start: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_DISCARD) |-> !image_start_ff)
      else $error("data phase while at image start");

endmodule

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psrle_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [OP_W-1:0]       rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   planar_sprite_rle_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // decoder image: configuration and parse state
   logic [ORGX_W-1:0]  org_x;
   logic [ORGY_W-1:0]  org_y;
   logic               tint_on;
   int                 plane_no;
   logic [1:0]         phase;
   logic [BYTE_W-1:0]  ctl_low;
   logic [1:0]         cur_cmd;
   logic [COUNT_W-1:0] remain;
   logic [ADDR_W-1:0]  dest;
   logic               at_start;

   logic [BYTE_W-1:0] stream_q[$];
   run_type           run_q[$];
   int                bytes_pushed = 0;
   int                bytes_taken  = 0;
   int                mismatches   = 0;
   int                idle_pct     = 0;
   int                send_gap     = 0;
   int                rsp_gap      = 0;
   int                quiet        = 0;
   run_type           drv_run;
   run_type           want;
   bit                hit;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] plane_base(input int p);
      int a;
      a = int'(org_y) * DEF_SCREEN_WIDTH + int'(org_x) + p;
      return a[ADDR_W-1:0];
   endfunction

   function automatic void step_dest(input logic [COUNT_W-1:0] n);
      dest = dest + {1'b0, n, 2'b00};
   endfunction

   function automatic run_type make_run(input logic [OP_W-1:0] op,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [COUNT_W-1:0] len,
                                        input logic [BYTE_W-1:0] val);
      run_type r;
      r.run_op        = op;
      r.run_address   = addr;
      r.run_length    = len;
      r.pixel_value   = val;
      r.out_of_screen = (op != OP_END) &&
                        (int'(addr) >= DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT);
      return r;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_ORIGIN_X:  org_x = val;
         CSR_ORIGIN_Y:  org_y = val[ORGY_W-1:0];
         CSR_TINT_MODE: tint_on = val[0];
         default: ;
      endcase
      if (at_start) dest = plane_base(0);
   endfunction

   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output run_type run);
      logic [15:0]        word;
      logic [1:0]         cmd;
      logic [COUNT_W-1:0] n;
      logic [ADDR_W-1:0]  addr;
      bit                 got;
      run      = '0;
      got      = 1'b0;
      addr     = dest;
      at_start = 1'b0;
      case (phase)
         PH_LOW: begin
            ctl_low = b;
            phase   = PH_HIGH;
         end
         PH_HIGH: begin
            word    = {b, ctl_low};
            cmd     = word[15:14];
            n       = word[COUNT_W-1:0];
            cur_cmd = cmd;
            remain  = n;
            phase   = PH_LOW;
            case (cmd)
               CMD_END: begin
                  plane_no++;
                  if (plane_no >= DEF_PLANE_COUNT) begin
                     plane_no = 0;
                     dest     = plane_base(0);
                     at_start = 1'b1;
                     run      = make_run(OP_END, '0, '0, '0);
                     got      = 1'b1;
                  end else begin
                     dest = plane_base(plane_no);
                  end
               end
               CMD_SKIP: step_dest(n);
               default: begin
                  if (tint_on) begin
                     step_dest(n);
                     remain = (cmd == CMD_REPEAT) ? COUNT_W'(1) : n;
                     if (remain != 0) phase = PH_DISCARD;
                     if (n != 0) begin
                        run = make_run(OP_TINT, addr, n, '0);
                        got = 1'b1;
                     end
                  end else if (cmd == CMD_REPEAT || n != 0) begin
                     phase = PH_DATA;
                  end
               end
            endcase
         end
         PH_DISCARD: begin
            remain = remain - COUNT_W'(1);
            if (remain == 0) phase = PH_LOW;
         end
         default: begin
            if (cur_cmd == CMD_REPEAT) begin
               n      = remain;
               phase  = PH_LOW;
               remain = '0;
               step_dest(n);
               if (n != 0) begin
                  run = make_run(OP_WRITE, addr, n, b);
                  got = 1'b1;
               end
            end else begin
               step_dest(COUNT_W'(1));
               remain = remain - COUNT_W'(1);
               if (remain == 0) phase = PH_LOW;
               run = make_run(OP_WRITE, addr, COUNT_W'(1), b);
               got = 1'b1;
            end
         end
      endcase
      return got;
   endfunction

   function automatic void check_field(input string name, input logic [ADDR_W-1:0] exp_val,
                                       input logic [ADDR_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   function automatic void push_byte(input logic [BYTE_W-1:0] b);
      stream_q.insert(stream_q.size(), b);
      bytes_pushed++;
   endfunction

   function automatic void push_word(input logic [1:0] cmd, input logic [COUNT_W-1:0] n);
      push_byte({n[7:0]});
      push_byte({cmd, n[13:8]});
   endfunction

   function automatic void add_command();
      logic [1:0]         cmd;
      logic [COUNT_W-1:0] n;
      int                 r;
      r   = $urandom_range(0, 2);
      cmd = (r == 0) ? CMD_SKIP : (r == 1) ? CMD_REPEAT : CMD_COPY;
      r   = $urandom_range(0, 15);
      if (r == 0)
         n = '0;
      else if (r == 1)
         n = (cmd == CMD_COPY) ? COUNT_W'($urandom_range(11, 48))
                               : COUNT_W'($urandom_range(0, 16383));
      else
         n = COUNT_W'($urandom_range(1, 10));
      push_word(cmd, n);
      if (cmd == CMD_REPEAT)
         push_byte(BYTE_W'($urandom));
      else if (cmd == CMD_COPY)
         for (int i = 0; i < int'(n); i++) push_byte(BYTE_W'($urandom));
   endfunction

   // truncated images leave the decoder mid-plane for the next settings
   function automatic void add_image(input bit truncated);
      int cut;
      int ops;
      cut = truncated ? $urandom_range(0, DEF_PLANE_COUNT - 1) : DEF_PLANE_COUNT;
      for (int p = 0; p < DEF_PLANE_COUNT; p++) begin
         ops = $urandom_range(0, 4);
         for (int i = 0; i < ops; i++) add_command();
         if (p == cut) return;
         push_word(CMD_END, ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom) : '0);
      end
   endfunction

   function automatic void add_noise();
      logic [BYTE_W-1:0] b;
      int                len;
      len = $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom);
         if (b[7:6] == CMD_COPY) b[5:0] = '0;
         push_byte(b);
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, CSR_DATA_W'(val));
   endtask

   task automatic settle();
      while (bytes_taken != bytes_pushed || run_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_origin_tint(input int ox, input int oy, input int tm);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_TINT_MODE, tm);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            hit = decode_byte(req_tdata, drv_run);
            if (hit) run_q.insert(run_q.size(), drv_run);
         end
         if (req_tvalid && !req_tready) begin
            // hold the pending transfer
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (stream_q.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else if (stream_q.size() != 0) begin
            req_tdata  <= stream_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (run_q.size() == 0) begin
               $display("%0t: unexpected run, expected none, actual op %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = run_q.pop_front();
               check_field("run_op", ADDR_W'(want.run_op), ADDR_W'(rsp_tuser));
               check_field("run_address", want.run_address, rsp_tdata[16:0]);
               check_field("run_length", ADDR_W'(want.run_length), ADDR_W'(rsp_tdata[30:17]));
               check_field("pixel_value", ADDR_W'(want.pixel_value), ADDR_W'(rsp_tdata[38:31]));
               check_field("out_of_screen", ADDR_W'(want.out_of_screen), ADDR_W'(rsp_tdata[39]));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int stop_at;
      int r;
      org_x    = '0;
      org_y    = '0;
      tint_on  = 1'b0;
      plane_no = 0;
      phase    = PH_LOW;
      ctl_low  = '0;
      cur_cmd  = CMD_END;
      remain   = '0;
      dest     = '0;
      at_start = 1'b1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // value mode, origin at zero; full skip runs past the screen end
      set_origin_tint(0, 0, 0);
      idle_pct = 20;
      push_word(CMD_SKIP, 14'h3FFF);
      push_word(CMD_REPEAT, 14'd5);
      push_byte(8'hFF);
      push_word(CMD_REPEAT, 14'd0);
      push_byte(8'h00);
      push_word(CMD_COPY, 14'd2);
      push_byte(8'h00);
      push_byte(8'hAA);
      push_word(CMD_COPY, 14'd0);
      for (int p = 0; p < DEF_PLANE_COUNT; p++) push_word(CMD_END, '0);
      settle();

      // tint mode at the far corner
      set_origin_tint(319, 199, 1);
      push_word(CMD_REPEAT, 14'h3FFF);
      push_byte(8'h55);
      push_word(CMD_COPY, 14'd2);
      push_byte(8'h12);
      push_byte(8'h34);
      push_word(CMD_REPEAT, 14'd0);
      push_byte(8'h77);
      push_word(CMD_COPY, 14'd0);
      push_word(CMD_SKIP, 14'd0);
      for (int p = 0; p < DEF_PLANE_COUNT; p++) push_word(CMD_END, '0);

      for (int k = 0; k < 7; k++) begin
         settle();
         if (k == 0)
            set_origin_tint(319, 199, 0);
         else if (k == 1)
            set_origin_tint(0, 0, 1);
         else
            set_origin_tint($urandom_range(0, 319), $urandom_range(0, 199),
                            $urandom_range(0, 1));
         idle_pct = (k == 6) ? 0 : 15 * $urandom_range(0, 2);
         stop_at  = bytes_pushed + 210;
         while (bytes_pushed < stop_at) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               add_noise();
            else
               add_image(r == 1);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && run_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
